// ===== sv/ubt_pkg.sv =====
// Shared types and constants for the serial-port bit timing block.
`default_nettype none
package ubt_pkg;

  // Item kinds on the input channel
  localparam logic [2:0] MODE_TICK    = 3'd0;
  localparam logic [2:0] MODE_WRITE   = 3'd1;
  localparam logic [2:0] MODE_READ    = 3'd2;
  localparam logic [2:0] MODE_T1_OVF  = 3'd3;
  localparam logic [2:0] MODE_T2_OVF  = 3'd4;
  localparam logic [2:0] MODE_T2_CLK  = 3'd5;

  // Register selects
  localparam logic [1:0] SEL_SBUF = 2'd0;
  localparam logic [1:0] SEL_SCON = 2'd1;
  localparam logic [1:0] SEL_PCON = 2'd2;

  // Serial-port operating modes from SCON bits 7..6
  localparam logic [1:0] UMODE_SHIFT = 2'd0;
  localparam logic [1:0] UMODE_8BIT  = 2'd1;

  // Bit period divisors
  localparam logic [5:0] DIV_MODE0 = 6'd12;
  localparam logic [5:0] DIV_FAST  = 6'd16;
  localparam logic [5:0] DIV_SLOW  = 6'd32;

  // Frame lengths in bits
  localparam logic [3:0] FRAME_MODE0 = 4'd8;
  localparam logic [3:0] FRAME_MODE1 = 4'd10;
  localparam logic [3:0] FRAME_MODE23 = 4'd11;

  // Reciprocal of 3 scaled by 2^17, exact for 14-bit operands
  localparam logic [15:0] RECIP3       = 16'hAAAB;
  localparam int          RECIP3_SHIFT = 17;

  localparam logic [3:0] CPM_RESET = 4'd12;

  typedef struct packed {
    logic [2:0] mode;
    logic [1:0] reg_sel;
    logic [7:0] write_data;
    logic [7:0] cycle_count;
    logic       rx_present;
    logic [7:0] rx_data;
    logic [1:0] t2_clock_bits;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       rx_done;
    logic       ti_flag;
    logic       ri_flag;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TX_DIV,
    ST_RX_DIV,
    ST_FINISH
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic div_tx;
    logic div_rx;
    logic finish;
  } ubt_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_tick;
    logic out_free;
  } ubt_stat_t;

endpackage
`default_nettype wire

// ===== sv/ubt_ctrl.sv =====
// Sequencer for one item: capture, two divide steps for ticks, finish.
`default_nettype none
module ubt_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  ubt_pkg::ubt_stat_t  stat,
  output ubt_pkg::ubt_cmd_t   cmd
);

  ubt_pkg::ctrl_state_t state_r, state_nxt;

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ubt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Advance through the steps of an item
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ubt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ubt_pkg::ST_FINISH;
        end
      end
      ubt_pkg::ST_TX_DIV: begin
        cmd.div_tx = 1'b1;
        state_nxt  = ubt_pkg::ST_RX_DIV;
      end
      ubt_pkg::ST_RX_DIV: begin
        cmd.div_rx = 1'b1;
        state_nxt  = ubt_pkg::ST_FINISH;
      end
      ubt_pkg::ST_FINISH: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ubt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ubt_pkg::ST_IDLE;
    endcase
    // Ticks go through the divide steps first
    if (state_r == ubt_pkg::ST_IDLE && in_valid && stat.is_tick) begin
      state_nxt = ubt_pkg::ST_TX_DIV;
    end
  end

endmodule
`default_nettype wire

// ===== sv/ubt_datapath.sv =====
// Serial-port state, shared bit-period divider and result register.
`default_nettype none
module ubt_datapath (
  input  wire                 clk,
  input  wire                 rst_n,
  input  ubt_pkg::in_item_t   in_item,
  input  wire                 cfg_we,
  input  wire  [3:0]          cfg_wdata,
  input  ubt_pkg::ubt_cmd_t   cmd,
  output ubt_pkg::ubt_stat_t  stat,
  output logic                out_valid,
  input  wire                 out_ready,
  output ubt_pkg::out_item_t  out_item
);

  logic sending_r, sending_nxt;
  logic receiving_r, receiving_nxt;
  logic ren_r, ren_nxt;
  logic smod_r, smod_nxt;
  logic [15:0] tx_clk_r, tx_clk_nxt, rx_clk_r, rx_clk_nxt;
  logic [15:0] tx_ovf_r, tx_ovf_nxt, rx_ovf_r, rx_ovf_nxt;
  logic [7:0]  tx_bits_r, tx_bits_nxt, rx_bits_r, rx_bits_nxt;
  logic [7:0]  tx_hold_r, tx_hold_nxt, rx_hold_r, rx_hold_nxt;
  logic [7:0]  scon_r, scon_nxt, pcon_r, pcon_nxt;
  logic [1:0]  uart_mode_r, uart_mode_nxt;
  logic [3:0]  frame_r, frame_nxt;
  logic [5:0]  divisor_r, divisor_nxt;
  logic [1:0]  t2clk_r, t2clk_nxt;
  logic [3:0]  cpm_r;

  ubt_pkg::in_item_t  item_r;
  ubt_pkg::out_item_t out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic        by_clock;
  logic [5:0]  div_eff;
  logic [15:0] div_src;
  logic [7:0]  div_bits;
  logic [13:0] div_y;
  logic [29:0] div_prod;
  logic [12:0] div_q;
  logic [15:0] div_qx;
  logic [4:0]  div_rem;
  logic [13:0] bits_sum;
  logic [7:0]  bits_new;
  logic [15:0] rem_ext;
  logic [11:0] clk_add;
  logic        tx_done, rx_start, rx_fin;
  logic [5:0]  rate_div;

  function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [11:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {5'd0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  assign stat.is_tick  = (in_item.mode == ubt_pkg::MODE_TICK);
  assign stat.out_free = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_item      = out_r;

  // Pick the counter and divisor for the current divide step
  assign by_clock = !uart_mode_r[0];
  assign div_eff  = (t2clk_r != 2'd0) ? ubt_pkg::DIV_FAST : divisor_r;
  assign div_src  = cmd.div_tx ? (by_clock ? tx_clk_r : tx_ovf_r)
                               : (by_clock ? rx_clk_r : rx_ovf_r);
  assign div_bits = cmd.div_tx ? tx_bits_r : rx_bits_r;
  assign div_y    = div_src[15:2];
  assign div_prod = {16'd0, div_y} * {14'd0, ubt_pkg::RECIP3};

  // Quotient and remainder by 12, 16 or 32
  always_comb begin
    div_q = 13'd0;
    div_qx = 16'd0;
    div_rem = 5'd0;
    case (div_eff)
      ubt_pkg::DIV_FAST: begin
        div_q   = {1'b0, div_src[15:4]};
        div_rem = {1'b0, div_src[3:0]};
      end
      ubt_pkg::DIV_SLOW: begin
        div_q   = {2'b00, div_src[15:5]};
        div_rem = div_src[4:0];
      end
      default: begin
        div_q   = div_prod[29:ubt_pkg::RECIP3_SHIFT];
        div_qx  = {div_q, 3'b000} + {1'b0, div_q, 2'b00};
        div_rem = 5'(div_src - div_qx);
      end
    endcase
  end

  assign bits_sum = {6'd0, div_bits} + {1'b0, div_q};
  assign bits_new = (bits_sum > 14'd255) ? 8'hFF : bits_sum[7:0];
  assign rem_ext  = {11'd0, div_rem};
  assign clk_add  = {4'd0, item_r.cycle_count} * {8'd0, cpm_r};
  assign rate_div = smod_r ? ubt_pkg::DIV_FAST : ubt_pkg::DIV_SLOW;

  assign tx_done  = sending_r && (tx_bits_r >= {4'd0, frame_r});
  assign rx_start = ren_r && !receiving_r && item_r.rx_present;
  assign rx_fin   = receiving_r && (rx_bits_r >= {4'd0, frame_r});

  // Next state for each step
  always_comb begin
    sending_nxt   = sending_r;
    receiving_nxt = receiving_r;
    ren_nxt       = ren_r;
    smod_nxt      = smod_r;
    tx_clk_nxt    = tx_clk_r;
    rx_clk_nxt    = rx_clk_r;
    tx_ovf_nxt    = tx_ovf_r;
    rx_ovf_nxt    = rx_ovf_r;
    tx_bits_nxt   = tx_bits_r;
    rx_bits_nxt   = rx_bits_r;
    tx_hold_nxt   = tx_hold_r;
    rx_hold_nxt   = rx_hold_r;
    scon_nxt      = scon_r;
    pcon_nxt      = pcon_r;
    uart_mode_nxt = uart_mode_r;
    frame_nxt     = frame_r;
    divisor_nxt   = divisor_r;
    t2clk_nxt     = t2clk_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;

    // Transmit bit count; timer-2 clocking pins the divisor here
    if (cmd.div_tx) begin
      divisor_nxt = div_eff;
      if (sending_r) begin
        tx_bits_nxt = bits_new;
        if (by_clock) tx_clk_nxt = rem_ext;
        else          tx_ovf_nxt = rem_ext;
      end
    end

    // Receive bit count
    if (cmd.div_rx && receiving_r) begin
      rx_bits_nxt = bits_new;
      if (by_clock) rx_clk_nxt = rem_ext;
      else          rx_ovf_nxt = rem_ext;
    end

    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
      out_nxt       = '0;
      unique case (item_r.mode)
        ubt_pkg::MODE_TICK: begin
          if (tx_done) begin
            sending_nxt      = 1'b0;
            scon_nxt[1]      = 1'b1;
            out_nxt.tx_valid = 1'b1;
            out_nxt.tx_byte  = tx_hold_r;
            tx_bits_nxt      = tx_bits_r - {4'd0, frame_r};
          end
          if (rx_start) begin
            receiving_nxt = 1'b1;
            rx_bits_nxt   = 8'd0;
            rx_clk_nxt    = 16'd0;
            rx_ovf_nxt    = 16'd0;
          end
          if (rx_fin) begin
            if (item_r.rx_present) begin
              rx_hold_nxt     = item_r.rx_data;
              scon_nxt[0]     = 1'b1;
              out_nxt.rx_done = 1'b1;
            end
            receiving_nxt = 1'b0;
            rx_bits_nxt   = rx_bits_r - {4'd0, frame_r};
          end
          tx_clk_nxt = sat_add16(tx_clk_nxt, clk_add);
          rx_clk_nxt = sat_add16(rx_clk_nxt, clk_add);
        end
        ubt_pkg::MODE_WRITE: begin
          unique case (item_r.reg_sel)
            ubt_pkg::SEL_SBUF: begin
              tx_hold_nxt = item_r.write_data;
              sending_nxt = 1'b1;
              tx_bits_nxt = 8'd0;
              tx_clk_nxt  = 16'd0;
              tx_ovf_nxt  = 16'd0;
            end
            ubt_pkg::SEL_SCON: begin
              scon_nxt      = item_r.write_data;
              uart_mode_nxt = item_r.write_data[7:6];
              ren_nxt       = item_r.write_data[4];
              if (item_r.write_data[7:6] == ubt_pkg::UMODE_SHIFT) begin
                frame_nxt   = ubt_pkg::FRAME_MODE0;
                divisor_nxt = ubt_pkg::DIV_MODE0;
              end else begin
                frame_nxt   = (item_r.write_data[7:6] == ubt_pkg::UMODE_8BIT)
                              ? ubt_pkg::FRAME_MODE1
                              : ubt_pkg::FRAME_MODE23;
                divisor_nxt = rate_div;
              end
            end
            ubt_pkg::SEL_PCON: begin
              pcon_nxt = item_r.write_data;
              smod_nxt = item_r.write_data[7];
              if (uart_mode_r != ubt_pkg::UMODE_SHIFT) begin
                divisor_nxt = item_r.write_data[7] ? ubt_pkg::DIV_FAST
                                                   : ubt_pkg::DIV_SLOW;
              end
            end
            default: ;
          endcase
        end
        ubt_pkg::MODE_READ: begin
          unique case (item_r.reg_sel)
            ubt_pkg::SEL_SBUF: out_nxt.read_data = rx_hold_r;
            ubt_pkg::SEL_SCON: out_nxt.read_data = scon_r;
            ubt_pkg::SEL_PCON: out_nxt.read_data = pcon_r;
            default:           out_nxt.read_data = 8'd0;
          endcase
        end
        ubt_pkg::MODE_T1_OVF, ubt_pkg::MODE_T2_OVF: begin
          tx_ovf_nxt = sat_add16(tx_ovf_r, 12'd1);
          rx_ovf_nxt = sat_add16(rx_ovf_r, 12'd1);
        end
        ubt_pkg::MODE_T2_CLK: begin
          if (t2clk_r == 2'd0) begin
            tx_ovf_nxt = 16'd0;
            rx_ovf_nxt = 16'd0;
          end
          t2clk_nxt = item_r.t2_clock_bits;
        end
        default: ;
      endcase
      out_nxt.ti_flag = scon_nxt[1];
      out_nxt.ri_flag = scon_nxt[0];
    end
  end

  // Capture the item and result payload
  always_ff @(posedge clk) begin
    if (cmd.capture) item_r <= in_item;
    out_r <= out_nxt;
  end

  // Hold serial-port state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sending_r   <= 1'b0;
      receiving_r <= 1'b0;
      ren_r       <= 1'b0;
      smod_r      <= 1'b0;
      tx_clk_r    <= 16'd0;
      rx_clk_r    <= 16'd0;
      tx_ovf_r    <= 16'd0;
      rx_ovf_r    <= 16'd0;
      tx_bits_r   <= 8'd0;
      rx_bits_r   <= 8'd0;
      tx_hold_r   <= 8'd0;
      rx_hold_r   <= 8'd0;
      scon_r      <= 8'd0;
      pcon_r      <= 8'd0;
      uart_mode_r <= 2'd0;
      frame_r     <= ubt_pkg::FRAME_MODE0;
      divisor_r   <= ubt_pkg::DIV_MODE0;
      t2clk_r     <= 2'd0;
      cpm_r       <= ubt_pkg::CPM_RESET;
      out_valid_r <= 1'b0;
    end else begin
      sending_r   <= sending_nxt;
      receiving_r <= receiving_nxt;
      ren_r       <= ren_nxt;
      smod_r      <= smod_nxt;
      tx_clk_r    <= tx_clk_nxt;
      rx_clk_r    <= rx_clk_nxt;
      tx_ovf_r    <= tx_ovf_nxt;
      rx_ovf_r    <= rx_ovf_nxt;
      tx_bits_r   <= tx_bits_nxt;
      rx_bits_r   <= rx_bits_nxt;
      tx_hold_r   <= tx_hold_nxt;
      rx_hold_r   <= rx_hold_nxt;
      scon_r      <= scon_nxt;
      pcon_r      <= pcon_nxt;
      uart_mode_r <= uart_mode_nxt;
      frame_r     <= frame_nxt;
      divisor_r   <= divisor_nxt;
      t2clk_r     <= t2clk_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) cpm_r <= cfg_wdata;
    end
  end

endmodule
`default_nettype wire

// ===== sv/uart_bit_timing_model.sv =====
// Top level of the serial-port bit timing block: controller plus datapath.
//
//   channel  ports                      moves
//   input    in_valid/in_ready/in_item  one bus access, tick or timer event
//   result   out_valid/out_ready/out_item  one result per input transaction
//   config   cfg_we/cfg_wdata           clocks per machine cycle
//
// A tick passes through accept, transmit divide, receive divide and finish;
// every other item through accept and finish. The single shared divider for
// the transmit and receive bit counters is why a tick needs both divide steps.
// Reset is synchronous on rst_n; no clearing pass is needed.
// Finish waits while the result register holds an untaken transaction.
`default_nettype none
module uart_bit_timing_model (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  ubt_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  wire                 out_ready,
  output ubt_pkg::out_item_t  out_item,
  input  wire                 cfg_we,
  input  wire  [3:0]          cfg_wdata
);

  ubt_pkg::ubt_cmd_t  cmd;
  ubt_pkg::ubt_stat_t stat;

  ubt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ubt_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // One item in flight at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while an item was in flight");

  // A completed transmit always shows TI
  a_tx_sets_ti: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.tx_valid) |-> out_item.ti_flag)
    else $error("transmit completion without TI");

  // A received byte always shows RI
  a_rx_sets_ri: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.rx_done) |-> out_item.ri_flag)
    else $error("receive completion without RI");

  // No transmit byte without a completion
  a_tx_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.tx_valid) |-> (out_item.tx_byte == 8'd0))
    else $error("transmit byte set without completion");

endmodule
`default_nettype wire

// ===== dv/tb_uart_bit_timing_model.sv =====
// Self-checking testbench for the serial-port bit timing block with a scoreboard.
module tb_uart_bit_timing_model;
  import ubt_pkg::*;

  // Selector and item codes the package leaves unnamed
  localparam logic [1:0] SEL_UNUSED     = 2'd3;
  localparam logic [2:0] MODE_UNUSED_LO = 3'd6;
  localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

  // Serial port operating modes from SCON bits 7..6
  localparam logic [1:0] UART_SHIFT      = 2'd0;
  localparam logic [1:0] UART_8BIT       = 2'd1;
  localparam logic [1:0] UART_9BIT_FIXED = 2'd2;
  localparam logic [1:0] UART_9BIT_VAR   = 2'd3;

  // Register bit positions
  localparam int SCON_RI   = 0;
  localparam int SCON_TI   = 1;
  localparam int SCON_REN  = 4;
  localparam int PCON_SMOD = 7;

  // Scoreboard: shadow copy of the port state, predicts one result per transaction
  class uart_frame_scoreboard;
    logic [3:0]  clk_per_mc;
    logic        sending, receiving, ren, smod;
    logic [15:0] tx_clk, rx_clk, tx_ovf, rx_ovf;
    logic [7:0]  tx_bits, rx_bits, tx_buf, rx_buf, scon, pcon;
    logic [1:0]  sm, t2clk;
    logic [3:0]  frame_len;
    logic [5:0]  divisor;
    out_item_t   pending_results[$];
    int          errors, checked, tx_seen, rx_seen;

    function new();
      clk_per_mc = CPM_RESET;
      sending = 1'b0; receiving = 1'b0; ren = 1'b0; smod = 1'b0;
      tx_clk = '0; rx_clk = '0; tx_ovf = '0; rx_ovf = '0;
      tx_bits = '0; rx_bits = '0; tx_buf = '0; rx_buf = '0;
      scon = '0; pcon = '0; sm = UART_SHIFT; t2clk = '0;
      frame_len = FRAME_MODE0;
      divisor = DIV_MODE0;
      errors = 0; checked = 0; tx_seen = 0; rx_seen = 0;
    endfunction

    function logic [15:0] add_sat(logic [15:0] a, logic [11:0] b);
      logic [16:0] s;
      s = a + b;
      return s[16] ? 16'hFFFF : s[15:0];
    endfunction

    // Turn whole bit periods into bits, keep the remainder, stop at 255
    function void advance_bits(inout logic [15:0] cnt, inout logic [7:0] nbits);
      logic [16:0] n;
      n = nbits + (cnt / divisor);
      cnt = cnt % divisor;
      nbits = (n > 17'd255) ? 8'd255 : n[7:0];
    endfunction

    function logic [5:0] rate_div();
      return smod ? DIV_FAST : DIV_SLOW;
    endfunction

    function void note_transaction(in_item_t it);
      out_item_t  r;
      logic       by_clock;
      logic [11:0] add;
      r = '0;
      case (it.mode)
        MODE_TICK: begin
          by_clock = (sm == UART_SHIFT) || (sm == UART_9BIT_FIXED);
          if (t2clk != 2'd0) divisor = DIV_FAST;
          if (sending) begin
            if (by_clock) advance_bits(tx_clk, tx_bits);
            else advance_bits(tx_ovf, tx_bits);
          end
          if (receiving) begin
            if (by_clock) advance_bits(rx_clk, rx_bits);
            else advance_bits(rx_ovf, rx_bits);
          end
          // Transmit completion
          if (sending && tx_bits >= frame_len) begin
            sending = 1'b0;
            scon[SCON_TI] = 1'b1;
            r.tx_valid = 1'b1;
            r.tx_byte = tx_buf;
            tx_bits = tx_bits - frame_len;
          end
          // Reception start
          if (ren && !receiving && it.rx_present) begin
            receiving = 1'b1;
            rx_bits = '0;
            rx_clk = '0;
            rx_ovf = '0;
          end
          // Reception completion, loading only when a byte is on the line
          if (receiving && rx_bits >= frame_len) begin
            if (it.rx_present) begin
              rx_buf = it.rx_data;
              scon[SCON_RI] = 1'b1;
              r.rx_done = 1'b1;
            end
            receiving = 1'b0;
            rx_bits = rx_bits - frame_len;
          end
          add = it.cycle_count * clk_per_mc;
          tx_clk = add_sat(tx_clk, add);
          rx_clk = add_sat(rx_clk, add);
        end
        MODE_WRITE: begin
          case (it.reg_sel)
            SEL_SBUF: begin
              tx_buf = it.write_data;
              sending = 1'b1;
              tx_bits = '0;
              tx_clk = '0;
              tx_ovf = '0;
            end
            SEL_SCON: begin
              scon = it.write_data;
              sm = it.write_data[7:6];
              ren = it.write_data[SCON_REN];
              if (sm == UART_SHIFT) begin
                frame_len = FRAME_MODE0;
                divisor = DIV_MODE0;
              end else begin
                frame_len = (sm == UART_8BIT) ? FRAME_MODE1 : FRAME_MODE23;
                divisor = rate_div();
              end
            end
            SEL_PCON: begin
              pcon = it.write_data;
              smod = it.write_data[PCON_SMOD];
              if (sm != UART_SHIFT) divisor = rate_div();
            end
            default: ;
          endcase
        end
        MODE_READ: begin
          case (it.reg_sel)
            SEL_SBUF: r.read_data = rx_buf;
            SEL_SCON: r.read_data = scon;
            SEL_PCON: r.read_data = pcon;
            default:  r.read_data = '0;
          endcase
        end
        MODE_T1_OVF, MODE_T2_OVF: begin
          tx_ovf = add_sat(tx_ovf, 12'd1);
          rx_ovf = add_sat(rx_ovf, 12'd1);
        end
        MODE_T2_CLK: begin
          if (t2clk == 2'd0) begin
            tx_ovf = '0;
            rx_ovf = '0;
          end
          t2clk = it.t2_clock_bits;
        end
        default: ;
      endcase
      r.ti_flag = scon[SCON_TI];
      r.ri_flag = scon[SCON_RI];
      pending_results.push_back(r);
    endfunction

    function void check_transaction(out_item_t got);
      out_item_t exp;
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing outstanding: %h", got);
        errors++;
        return;
      end
      exp = pending_results.pop_front();
      checked++;
      if (exp.tx_valid) tx_seen++;
      if (exp.rx_done) rx_seen++;
      if (got.read_data !== exp.read_data) begin
        $error("read_data: expected %0h, actual %0h", exp.read_data, got.read_data);
        errors++;
      end
      if (got.tx_valid !== exp.tx_valid) begin
        $error("tx_valid: expected %0b, actual %0b", exp.tx_valid, got.tx_valid);
        errors++;
      end
      if (got.tx_byte !== exp.tx_byte) begin
        $error("tx_byte: expected %0h, actual %0h", exp.tx_byte, got.tx_byte);
        errors++;
      end
      if (got.rx_done !== exp.rx_done) begin
        $error("rx_done: expected %0b, actual %0b", exp.rx_done, got.rx_done);
        errors++;
      end
      if (got.ti_flag !== exp.ti_flag) begin
        $error("ti_flag: expected %0b, actual %0b", exp.ti_flag, got.ti_flag);
        errors++;
      end
      if (got.ri_flag !== exp.ri_flag) begin
        $error("ri_flag: expected %0b, actual %0b", exp.ri_flag, got.ri_flag);
        errors++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  in_item_t   in_item;
  logic       out_valid;
  logic       out_ready;
  out_item_t  out_item;
  logic       cfg_we;
  logic [3:0] cfg_wdata;

  uart_frame_scoreboard sb;
  bit no_idle;
  int items_sent;
  int settings_used;

  uart_bit_timing_model u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Stall the result side at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= no_idle || ($urandom_range(99) >= 23);
    end
  end

  // Observe both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_transaction(in_item);
      if (out_valid && out_ready) sb.check_transaction(out_item);
    end
  end

  function automatic in_item_t random_item();
    in_item_t it;
    it.mode          = 3'($urandom_range(7));
    it.reg_sel       = 2'($urandom_range(3));
    it.write_data    = 8'($urandom);
    it.cycle_count   = 8'($urandom);
    it.rx_present    = 1'($urandom_range(1));
    it.rx_data       = 8'($urandom);
    it.t2_clock_bits = 2'($urandom_range(3));
    return it;
  endfunction

  // Present one transaction, hold until taken, then maybe idle
  task automatic send_item(input in_item_t it);
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    if (it.mode <= MODE_T2_CLK) items_sent++;
    while (!no_idle && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_tick(input logic [7:0] cycles, input logic present);
    in_item_t it;
    it = random_item();
    it.mode = MODE_TICK;
    it.cycle_count = cycles;
    it.rx_present = present;
    send_item(it);
  endtask

  task automatic send_write(input logic [1:0] sel, input logic [7:0] data);
    in_item_t it;
    it = random_item();
    it.mode = MODE_WRITE;
    it.reg_sel = sel;
    it.write_data = data;
    send_item(it);
  endtask

  task automatic send_read(input logic [1:0] sel);
    in_item_t it;
    it = random_item();
    it.mode = MODE_READ;
    it.reg_sel = sel;
    send_item(it);
  endtask

  task automatic send_ovf();
    in_item_t it;
    it = random_item();
    it.mode = $urandom_range(1) ? MODE_T1_OVF : MODE_T2_OVF;
    send_item(it);
  endtask

  task automatic send_t2(input logic [1:0] t2bits);
    in_item_t it;
    it = random_item();
    it.mode = MODE_T2_CLK;
    it.t2_clock_bits = t2bits;
    send_item(it);
  endtask

  // Hold the input side until every outstanding result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_clocks_per_cycle(input logic [3:0] v);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.clk_per_mc = v;
    settings_used++;
  endtask

  // One burst of random traffic, mostly complete frames
  task automatic run_random_burst();
    int          pick, n, k;
    logic [1:0]  sm;
    logic        smod;
    logic [7:0]  ctl;
    pick = $urandom_range(99);
    if (pick < 50) begin
      // Clock-timed frame: mode 0 or 2
      sm = $urandom_range(1) ? UART_9BIT_FIXED : UART_SHIFT;
      ctl = 8'($urandom);
      ctl[7:6] = sm;
      ctl[SCON_REN] = ($urandom_range(99) < 70);
      send_write(SEL_SCON, ctl);
      if ($urandom_range(1)) send_write(SEL_PCON, 8'($urandom));
      if ($urandom_range(9) == 0) send_t2(2'($urandom_range(3)));
      send_write(SEL_SBUF, 8'($urandom));
      n = $urandom_range(3, 10);
      repeat (n) begin
        if ($urandom_range(4) == 0) send_read(2'($urandom_range(2)));
        send_tick(8'($urandom), $urandom_range(99) < 80);
      end
    end else if (pick < 58) begin
      // Overflow-timed frame: mode 1 or 3
      sm = $urandom_range(1) ? UART_8BIT : UART_9BIT_VAR;
      smod = ($urandom_range(3) != 0);
      ctl = 8'($urandom);
      ctl[7:6] = sm;
      ctl[SCON_REN] = 1'($urandom_range(1));
      send_write(SEL_SCON, ctl);
      send_write(SEL_PCON, {smod, 7'($urandom)});
      send_write(SEL_SBUF, 8'($urandom));
      k = ((sm == UART_8BIT) ? 10 : 11) * (smod ? 16 : 32) + $urandom_range(20);
      if ($urandom_range(3) == 0) k = $urandom_range(1, k);
      repeat (k) begin
        if ($urandom_range(9) == 0) send_tick(8'($urandom), 1'($urandom_range(1)));
        else send_ovf();
      end
      send_tick(8'($urandom), 1'($urandom_range(1)));
      send_read(SEL_SCON);
    end else if (pick < 68) begin
      // Long ticks to push the clock counters toward saturation
      n = $urandom_range(5, 25);
      repeat (n) send_tick(8'($urandom_range(200, 255)), 1'b0);
    end else if (pick < 86) begin
      // Register traffic on every selector
      n = $urandom_range(4, 12);
      repeat (n) begin
        case ($urandom_range(2))
          0: send_write(2'($urandom_range(3)), 8'($urandom));
          1: send_read(2'($urandom_range(3)));
          default: send_t2(2'($urandom_range(3)));
        endcase
      end
    end else begin
      n = $urandom_range(3, 10);
      repeat (n) send_item(random_item());
    end
  endtask

  initial begin
    logic [3:0] cpm_plan [5];
    in_item_t   it;
    int         directed_items;
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    no_idle = 1'b0;
    items_sent = 0;
    settings_used = 1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values and the unused selector and item codes
    send_read(SEL_SBUF);
    send_read(SEL_SCON);
    send_read(SEL_PCON);
    send_read(SEL_UNUSED);
    send_write(SEL_UNUSED, 8'hFF);
    it = random_item();
    it.mode = MODE_UNUSED_LO;
    send_item(it);
    it.mode = MODE_UNUSED_HI;
    send_item(it);
    // Control write keeps the RI bit it carries; enable reception in mode 0
    send_write(SEL_SCON, 8'h13);
    send_write(SEL_PCON, 8'h80);
    // Reception that ends with no byte on the line
    send_tick(8'd255, 1'b1);
    send_tick(8'd0, 1'b0);
    // Reception that loads the buffer, then read it back
    send_tick(8'd255, 1'b1);
    it = random_item();
    it.mode = MODE_TICK;
    it.cycle_count = 8'd8;
    it.rx_present = 1'b1;
    it.rx_data = 8'hA5;
    send_item(it);
    send_read(SEL_SBUF);
    // Transmit with a saturated bit count
    send_write(SEL_SBUF, 8'hFF);
    send_tick(8'd255, 1'b0);
    send_tick(8'd0, 1'b0);
    // Overflow-timed mode, timer events and timer-2 clocking
    send_write(SEL_SCON, 8'hC0);
    send_write(SEL_SBUF, 8'h00);
    it = random_item();
    it.mode = MODE_T1_OVF;
    send_item(it);
    it.mode = MODE_T2_OVF;
    send_item(it);
    send_t2(2'd3);
    send_t2(2'd0);
    send_write(SEL_PCON, 8'h00);
    send_tick(8'd255, 1'b0);
    directed_items = items_sent;

    // Random phases, each under its own clock-rate setting
    cpm_plan = '{4'd15, 4'd1, 4'd0, 4'd12, 4'd0};
    cpm_plan[4] = 4'($urandom_range(2, 11));
    for (int ph = 0; ph < 5; ph++) begin
      set_clocks_per_cycle(cpm_plan[ph]);
      no_idle = (ph == 1);
      while (items_sent < directed_items + (ph + 1) * 390) run_random_burst();
    end
    no_idle = 1'b0;

    drain_results();
    repeat (20) @(posedge clk);
    if (sb.pending_results.size() != 0) begin
      $error("%0d expected results never arrived", sb.pending_results.size());
      sb.errors++;
    end
    $display("Covered %0d transactions across %0d clock-rate settings, all four port modes.",
             sb.checked, settings_used);
    $display("Frames completed: %0d transmitted, %0d received.", sb.tx_seen, sb.rx_seen);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog on the whole run
  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== uart_bit_timing_model.f =====
sv/ubt_pkg.sv
sv/ubt_ctrl.sv
sv/ubt_datapath.sv
sv/uart_bit_timing_model.sv
dv/tb_uart_bit_timing_model.sv
